FILE: rtl/core/wcsk_pkg.sv
package wcsk_pkg;

  // Operation codes carried in the input selector.
  localparam logic [2:0] FUNC_RESET  = 3'd0;
  localparam logic [2:0] FUNC_ANCHOR = 3'd1;
  localparam logic [2:0] FUNC_TICK   = 3'd2;
  localparam logic [2:0] FUNC_QUERY  = 3'd3;
  localparam logic [2:0] FUNC_RESYNC = 3'd4;

  // Resync status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_STOPPED = 2'd1;
  localparam logic [1:0] STATUS_DRIFT   = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_DRIFT_LIMIT = 1'b0;
  localparam logic CFG_STOPPED_THR = 1'b1;

  // Microseconds per second, and the accumulator wrap point of 2^32 seconds.
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic [52:0] US_WRAP  = {1'b0, US_PER_S, 32'd0};

  // Reciprocal of 15 scaled by 2^34; exact for a 30-bit dividend.
  localparam logic [30:0] RECIP_15    = 31'd1145324613;
  localparam int          RECIP_SHIFT = 34;

  // Seconds are the accumulator shifted right by six and divided by 15625.
  // The top 32 bits times this reciprocal, scaled by 2^45, give an estimate
  // that is at most three short; a remainder check supplies the rest.
  localparam logic [13:0] US_PER_S_ODD = 14'd15625;
  localparam logic [31:0] RECIP_15625  = 32'd2251799813;

  // What a pipeline word has to report once it reaches the output.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_QUERY,
    KIND_RESYNC
  } kind_t;

  // Word leaving the state-update stage.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic        stopped;
    logic [51:0] acc;
    logic [31:0] base;
    logic [31:0] src;
  } exec_t;

  // Word moving through the seconds divider.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic        stopped;
    logic [31:0] base;
    logic [31:0] src;
    logic [31:0] quo;
  } divw_t;

  // One result item.
  typedef struct packed {
    logic               time_ok;
    logic [31:0]        epoch;
    logic [26:0]        minute;
    logic [1:0]         status;
    logic signed [31:0] drift;
  } res_t;

endpackage

FILE: rtl/core/wcsk_exec.sv
module wcsk_exec
  import wcsk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_now,
  input  logic        in_src_valid,
  input  logic [31:0] in_src,
  input  logic [35:0] thr_us,
  output exec_t       p_o
);

  // Clock state. The elapsed time since the anchor is one microsecond
  // accumulator kept modulo 2^32 seconds, so no division sits in this loop.
  logic        valid_r, valid_nxt;
  logic [31:0] base_r, base_nxt;
  logic [31:0] last_r, last_nxt;
  logic [51:0] acc_r, acc_nxt;
  exec_t       p_r, p_nxt;

  logic [31:0] delta;
  logic [52:0] sum;
  logic [52:0] sum_wrap;
  logic [51:0] acc_adv;
  logic        stopped;

  // Advance the accumulator by the wrapped counter delta.
  always_comb begin
    delta    = in_now - last_r;
    sum      = {1'b0, acc_r} + {21'd0, delta};
    sum_wrap = sum - US_WRAP;
    acc_adv  = (sum >= US_WRAP) ? sum_wrap[51:0] : sum[51:0];
    stopped  = (in_src == base_r) && (acc_adv >= {16'd0, thr_us});
  end

  // Apply the operation to the state and build the outgoing word.
  always_comb begin
    valid_nxt   = valid_r;
    base_nxt    = base_r;
    last_nxt    = last_r;
    acc_nxt     = acc_r;
    p_nxt.valid   = in_valid;
    p_nxt.kind    = KIND_NONE;
    p_nxt.stopped = stopped;
    p_nxt.acc     = acc_adv;
    p_nxt.base    = base_r;
    p_nxt.src     = in_src;
    if (in_valid) begin
      case (in_func)
        FUNC_RESET: begin
          valid_nxt = 1'b0;
          base_nxt  = '0;
          last_nxt  = '0;
          acc_nxt   = '0;
        end
        FUNC_ANCHOR: begin
          valid_nxt = in_src_valid;
          base_nxt  = in_src_valid ? in_src : '0;
          last_nxt  = in_src_valid ? in_now : '0;
          acc_nxt   = '0;
        end
        FUNC_TICK: begin
          if (valid_r) begin
            last_nxt = in_now;
            acc_nxt  = acc_adv;
          end
        end
        FUNC_QUERY: begin
          if (valid_r) begin
            p_nxt.kind = KIND_QUERY;
          end
        end
        FUNC_RESYNC: begin
          if (valid_r && in_src_valid) begin
            p_nxt.kind = KIND_RESYNC;
          end
          if (!in_src_valid || (valid_r && stopped)) begin
            valid_nxt = 1'b0;
            base_nxt  = '0;
            last_nxt  = '0;
            acc_nxt   = '0;
          end else begin
            valid_nxt = 1'b1;
            base_nxt  = in_src;
            last_nxt  = in_now;
            acc_nxt   = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      base_r    <= '0;
      last_r    <= '0;
      acc_r     <= '0;
      p_r.valid <= 1'b0;
    end else if (en) begin
      valid_r <= valid_nxt;
      base_r  <= base_nxt;
      last_r  <= last_nxt;
      acc_r   <= acc_nxt;
      p_r     <= p_nxt;
    end
  end

  assign p_o = p_r;

endmodule

FILE: rtl/core/wcsk_div.sv
module wcsk_div
  import wcsk_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  exec_t p_i,
  output divw_t d_o
);

  // Stage 1: reciprocal product of the upper accumulator bits.
  divw_t       s1_r, s1_nxt;
  logic [45:0] s1_x_r;
  logic [63:0] s1_prod_r;

  // Stage 2: quotient estimate and the leftover of the shifted accumulator.
  divw_t       s2_r, s2_nxt;
  logic [15:0] s2_rem_r;

  // Stage 3: corrected quotient.
  divw_t       s3_r, s3_nxt;

  logic [31:0] q_est;
  logic [45:0] q_back;
  logic [45:0] rem_full;
  logic [1:0]  corr;

  // Carry the side fields into the first stage.
  always_comb begin
    s1_nxt.valid   = p_i.valid;
    s1_nxt.kind    = p_i.kind;
    s1_nxt.stopped = p_i.stopped;
    s1_nxt.base    = p_i.base;
    s1_nxt.src     = p_i.src;
    s1_nxt.quo     = '0;
  end

  // The estimate never exceeds the true quotient, so the leftover is below
  // four times the divisor and fits in 16 bits.
  always_comb begin
    q_est      = s1_prod_r[62:31];
    q_back     = 46'(q_est) * 46'(US_PER_S_ODD);
    rem_full   = s1_x_r - q_back;
    s2_nxt     = s1_r;
    s2_nxt.quo = q_est;
  end

  // Add the whole divisors still held in the leftover.
  always_comb begin
    if (s2_rem_r >= 16'(3 * US_PER_S_ODD)) begin
      corr = 2'd3;
    end else if (s2_rem_r >= 16'(2 * US_PER_S_ODD)) begin
      corr = 2'd2;
    end else if (s2_rem_r >= 16'(US_PER_S_ODD)) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
    s3_nxt     = s2_r;
    s3_nxt.quo = s2_r.quo + {30'd0, corr};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
    end else if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x_r    <= p_i.acc[51:6];
      s1_prod_r <= 64'(p_i.acc[51:20]) * 64'(RECIP_15625);
      s2_rem_r  <= rem_full[15:0];
    end
  end

  assign d_o = s3_r;

endmodule

FILE: rtl/core/wcsk_post.sv
module wcsk_post
  import wcsk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  divw_t       d_i,
  input  logic [15:0] drift_limit,
  output logic        res_valid_o,
  output res_t        res_o
);

  // Stage a: believed epoch.
  logic        a_valid_r;
  kind_t       a_kind_r;
  logic        a_stop_r;
  logic [31:0] a_src_r;
  logic [31:0] a_epoch_r;

  // Stage b: minute product and drift check.
  logic        b_valid_r;
  kind_t       b_kind_r;
  logic        b_stop_r;
  logic [31:0] b_epoch_r;
  logic [60:0] b_prod_r;
  logic [31:0] b_diff_r;
  logic        b_over_r;

  // Stage c: formatted result.
  logic        res_valid_r;
  res_t        res_r;
  res_t        res_nxt;

  logic [31:0] diff;
  logic [32:0] diff_ext;
  logic [32:0] lim_pos;
  logic [32:0] lim_neg;
  logic        over;

  // Drift exceeds the limit in either direction.
  always_comb begin
    diff     = a_src_r - a_epoch_r;
    diff_ext = {diff[31], diff};
    lim_pos  = {17'd0, drift_limit};
    lim_neg  = 33'd0 - lim_pos;
    over     = ($signed(diff_ext) > $signed(lim_pos)) ||
               ($signed(diff_ext) < $signed(lim_neg));
  end

  // Result fields by kind; anything else reports zeros.
  always_comb begin
    res_nxt = '0;
    case (b_kind_r)
      KIND_QUERY: begin
        res_nxt.time_ok = 1'b1;
        res_nxt.epoch   = b_epoch_r;
        res_nxt.minute  = b_prod_r[60:RECIP_SHIFT];
      end
      KIND_RESYNC: begin
        res_nxt.drift = $signed(b_diff_r);
        if (b_stop_r) begin
          res_nxt.status = STATUS_STOPPED;
        end else if (b_over_r) begin
          res_nxt.status = STATUS_DRIFT;
        end else begin
          res_nxt.status = STATUS_OK;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= d_i.valid;
      b_valid_r   <= a_valid_r;
      res_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_kind_r  <= d_i.kind;
      a_stop_r  <= d_i.stopped;
      a_src_r   <= d_i.src;
      a_epoch_r <= d_i.base + d_i.quo;
      b_kind_r  <= a_kind_r;
      b_stop_r  <= a_stop_r;
      b_epoch_r <= a_epoch_r;
      b_prod_r  <= 61'(a_epoch_r[31:2]) * 61'(RECIP_15);
      b_diff_r  <= diff;
      b_over_r  <= over;
      res_r     <= res_nxt;
    end
  end

  assign res_valid_o = res_valid_r;
  assign res_o       = res_r;

endmodule

FILE: rtl/core/wall_clock_seconds_keeper.sv
// Wall-clock seconds keeper. Each transfer on the input carries an operation
// (reset, anchor, tick, query, resync) with a sample of a free-running 32-bit
// microsecond counter and an epoch value; each one yields exactly one result
// transfer, in order. The block takes one item per cycle while the skid entry
// is free. A result passes through one input register, one state-update
// stage, three stages that turn the elapsed microseconds into seconds with a
// reciprocal multiply and a remainder check, three stages that add the
// anchor epoch, form the minute and check drift, and the output register. A
// one-entry skid buffer behind the output register holds a result that finds
// the output register full, and closes the input while it is held. The threshold
// register is stored as microseconds and applies from the cycle after a write.
module wall_clock_seconds_keeper
  import wcsk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Configuration writes.
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // now_us, source_valid, source_epoch
  input  logic [2:0]  in_tuser,   // func
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // epoch_out, minute_out, resync_status, drift_seconds
  output logic        out_tuser   // time_ok
);

  logic        en;

  // Configuration registers.
  logic [15:0] drift_limit_r;
  logic [35:0] thr_us_r;

  // Input register.
  logic        s0_valid_r;
  logic [2:0]  s0_func_r;
  logic [31:0] s0_now_r;
  logic        s0_src_valid_r;
  logic [31:0] s0_src_r;

  exec_t       p_w;
  divw_t       d_w;
  logic        res_valid;
  res_t        res;

  // Output register and skid entry.
  logic        out_valid_r, out_valid_nxt;
  res_t        out_r, out_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  res_t        skid_r, skid_nxt;
  logic        take;
  logic        out_free;

  // The pipeline moves whenever the skid entry is free.
  assign en        = !skid_valid_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drift_limit_r <= 16'd2;
      thr_us_r      <= 36'd5000000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DRIFT_LIMIT: drift_limit_r <= cfg_wdata;
        CFG_STOPPED_THR: thr_us_r      <= 36'(cfg_wdata) * 36'(US_PER_S);
        default: begin
        end
      endcase
    end
  end

  // Capture an input transfer, or a bubble when none is offered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_func_r      <= in_tuser;
      s0_now_r       <= in_tdata[31:0];
      s0_src_valid_r <= in_tdata[32];
      s0_src_r       <= in_tdata[64:33];
    end
  end

  wcsk_exec u_exec (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (s0_valid_r),
    .in_func      (s0_func_r),
    .in_now       (s0_now_r),
    .in_src_valid (s0_src_valid_r),
    .in_src       (s0_src_r),
    .thr_us       (thr_us_r),
    .p_o          (p_w)
  );

  wcsk_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .p_i   (p_w),
    .d_o   (d_w)
  );

  wcsk_post u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .d_i         (d_w),
    .drift_limit (drift_limit_r),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Route a finished result to the output register or the skid entry.
  always_comb begin
    take           = out_valid_r && out_tready;
    out_free       = !out_valid_r || take;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    skid_valid_nxt = skid_valid_r;
    skid_nxt       = skid_r;
    if (en && res_valid) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_nxt       = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res;
      end
    end else if (skid_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_nxt        = skid_r;
      skid_valid_nxt = 1'b0;
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.time_ok;
  assign out_tdata  = {3'd0, out_r.drift, out_r.status, out_r.minute, out_r.epoch};

endmodule

FILE: test/wall_clock_seconds_keeper_tb.sv
module wall_clock_seconds_keeper_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wcsk_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int PIPE_DEPTH  = 20;

  // Tracks the believed wall-clock time and the results each transfer must produce.
  class epoch_tracker;
    logic        running;
    logic [31:0] secs;
    logic [31:0] anchor_secs;
    logic [31:0] prev_sample;
    logic [19:0] sub_us;
    logic [15:0] drift_max;
    logic [15:0] stop_secs;
    res_t        pending_results[$];
    int          mismatches;

    function new();
      drift_max  = 16'd2;
      stop_secs  = 16'd5;
      mismatches = 0;
      stop_clock();
    endfunction

    function void stop_clock();
      running     = 1'b0;
      secs        = '0;
      anchor_secs = '0;
      prev_sample = '0;
      sub_us      = '0;
    endfunction

    function void start_clock(logic [31:0] epoch, logic [31:0] sample);
      running     = 1'b1;
      secs        = epoch;
      anchor_secs = epoch;
      prev_sample = sample;
      sub_us      = '0;
    endfunction

    // Whole seconds in the carried remainder plus a sample delta, with no overflow.
    function logic [31:0] whole_secs(logic [19:0] rem, logic [31:0] delta);
      return delta / US_PER_S + (32'(rem) + delta % US_PER_S) / US_PER_S;
    endfunction

    function logic [31:0] time_at(logic [31:0] sample);
      return secs + whole_secs(sub_us, sample - prev_sample);
    endfunction

    // Advance the clock for one accepted input transfer and queue its result.
    function void note_command(logic [2:0] func, logic [31:0] sample, logic src_ok,
                               logic [31:0] src_secs);
      res_t        r;
      logic [31:0] delta;
      logic [31:0] now_secs;
      logic [31:0] diff;
      int          drift;
      int          lim;
      r = '0;
      case (func)
        FUNC_RESET: stop_clock();
        FUNC_ANCHOR: begin
          if (src_ok) start_clock(src_secs, sample);
          else stop_clock();
        end
        FUNC_TICK: begin
          if (running) begin
            delta       = sample - prev_sample;
            secs        = secs + whole_secs(sub_us, delta);
            sub_us      = 20'((32'(sub_us) + delta % US_PER_S) % US_PER_S);
            prev_sample = sample;
          end
        end
        FUNC_QUERY: begin
          if (running) begin
            now_secs  = time_at(sample);
            r.time_ok = 1'b1;
            r.epoch   = now_secs;
            r.minute  = 27'(now_secs / 32'd60);
          end
        end
        FUNC_RESYNC: begin
          if (!src_ok) begin
            stop_clock();
          end else if (!running) begin
            start_clock(src_secs, sample);
          end else begin
            now_secs = time_at(sample);
            diff     = src_secs - now_secs;
            drift    = signed'(diff);
            lim      = int'(drift_max);
            r.drift  = diff;
            // An RTC still showing the anchor after enough believed time is stopped.
            if (src_secs == anchor_secs && (now_secs - anchor_secs) >= 32'(stop_secs)) begin
              stop_clock();
              r.status = STATUS_STOPPED;
            end else begin
              start_clock(src_secs, sample);
              if (drift > lim || drift < -lim) r.status = STATUS_DRIFT;
            end
          end
        end
        default: ;
      endcase
      pending_results.push_back(r);
    endfunction

    // Compare one accepted output transfer against the oldest queued result.
    function void check_report(logic ok_bit, logic [95:0] data);
      res_t got;
      res_t want;
      got.time_ok = ok_bit;
      got.epoch   = data[31:0];
      got.minute  = data[58:32];
      got.status  = data[60:59];
      got.drift   = data[92:61];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with none outstanding: ok=%0b epoch=%0d minute=%0d status=%0d drift=%0d",
                   got.time_ok, got.epoch, got.minute, got.status, got.drift);
        return;
      end
      want = pending_results.pop_front();
      if (got.time_ok !== want.time_ok || got.epoch !== want.epoch ||
          got.minute !== want.minute || got.status !== want.status ||
          got.drift !== want.drift) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: expected ok=%0b epoch=%0d minute=%0d status=%0d drift=%0d",
                   want.time_ok, want.epoch, want.minute, want.status, want.drift);
          $display("       actual   ok=%0b epoch=%0d minute=%0d status=%0d drift=%0d",
                   got.time_ok, got.epoch, got.minute, got.status, got.drift);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // now_us, source_valid, source_epoch
  logic [2:0]  in_tuser;   // func
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // epoch_out, minute_out, resync_status, drift_seconds
  logic        out_tuser;  // time_ok

  epoch_tracker tracker;
  logic [31:0]  sample_us;
  bit           idle_on;
  int           hold_left;
  int           cycles;

  wall_clock_seconds_keeper DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one item, optionally after a short gap, and hold it until the transfer.
  task automatic send_item(logic [2:0] func, logic [31:0] sample, logic src_ok,
                           logic [31:0] src_secs);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {7'd0, src_secs, src_ok, sample};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_command(func, sample, src_ok, src_secs);
  endtask

  // Drain every outstanding result, then write both limits while the block is idle.
  task automatic settle_and_configure(logic [15:0] lim, logic [15:0] thr);
    in_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_DRIFT_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_index <= CFG_STOPPED_THR;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.drift_max = lim;
    tracker.stop_secs = thr;
    repeat (2) @(posedge clk);
  endtask

  // Mostly modest steps of the microsecond counter, sometimes long ones that wrap.
  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1, 2:    return $urandom_range(0, 200_000_000);
      3:       return 32'($urandom_range(0, 20)) * 32'(US_PER_S);
      default: return $urandom_range(0, 3_000_000);
    endcase
  endfunction

  function automatic logic [31:0] pick_epoch();
    case ($urandom_range(0, 5))
      0:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 300));
      1:       return $urandom_range(0, 300);
      default: return $urandom;
    endcase
  endfunction

  // RTC readings near the believed time, at the drift limits, or frozen at the anchor.
  function automatic logic [31:0] pick_rtc();
    logic [31:0] now_secs;
    logic [31:0] lim;
    int          k;
    if (!tracker.running) return $urandom;
    now_secs = tracker.time_at(sample_us);
    lim      = 32'(tracker.drift_max);
    k        = int'($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 5))
      0:       return now_secs + 32'(k);
      1:       return now_secs + lim + 32'(k);
      2:       return now_secs - lim + 32'(k);
      3, 4:    return tracker.anchor_secs;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_directed();
    int c;
    send_item(FUNC_QUERY, 32'd0, 1'b0, 32'd0);
    send_item(FUNC_TICK, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    // Resync on a clock that is not running anchors it.
    send_item(FUNC_RESYNC, 32'hFFFF_FF00, 1'b1, 32'hFFFF_FFF0);
    // The counter wraps between these samples.
    send_item(FUNC_TICK, 32'h000F_4200, 1'b0, 32'd0);
    send_item(FUNC_QUERY, 32'h0020_0000, 1'b0, 32'd0);
    // An invalid RTC reading clears the clock.
    send_item(FUNC_RESYNC, 32'h0030_0000, 1'b0, 32'hFFFF_FFFF);
    send_item(FUNC_ANCHOR, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    // The epoch wraps past 2^32 seconds.
    send_item(FUNC_QUERY, 32'h7FFF_FFFF, 1'b0, 32'd0);
    send_item(FUNC_ANCHOR, 32'd5, 1'b0, 32'd77);
    send_item(FUNC_QUERY, 32'd6, 1'b1, 32'd0);
    send_item(FUNC_ANCHOR, 32'd0, 1'b1, 32'd1000);
    send_item(FUNC_TICK, 32'd999_999, 1'b0, 32'd0);
    // The sub-second remainder carries into a whole second.
    send_item(FUNC_TICK, 32'd1_000_000, 1'b0, 32'd0);
    // Drift exactly at the limit, then beyond it on either side.
    send_item(FUNC_RESYNC, 32'd1_000_000, 1'b1, 32'd1003);
    send_item(FUNC_RESYNC, 32'd1_000_000, 1'b1, 32'd1006);
    send_item(FUNC_RESYNC, 32'd1_000_000, 1'b1, 32'd1003);
    // The RTC still shows the anchor after the threshold has passed.
    send_item(FUNC_RESYNC, 32'd6_000_000, 1'b1, 32'd1003);
    // Unused operation codes are ignored.
    for (c = int'(FUNC_RESYNC) + 1; c < 8; c++)
      send_item(3'(c), 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_item(FUNC_ANCHOR, 32'd0, 1'b1, 32'd0);
    send_item(FUNC_RESET, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_item(FUNC_ANCHOR, 32'd0, 1'b1, 32'd0);
    // Most negative and most positive drift.
    send_item(FUNC_RESYNC, 32'd0, 1'b1, 32'h8000_0000);
    send_item(FUNC_ANCHOR, 32'd0, 1'b1, 32'h8000_0001);
    send_item(FUNC_RESYNC, 32'd0, 1'b1, 32'd0);
    send_item(FUNC_QUERY, 32'hFFFF_FFFF, 1'b0, 32'd0);
    sample_us = 32'hFFFF_FFFF;
  endtask

  // Anchored sessions of ticks, queries and resyncs, with some stray items mixed in.
  task automatic run_random(int n_items);
    int done;
    int pick;
    done = 0;
    while (done < n_items) begin
      sample_us = sample_us + pick_delta();
      send_item(FUNC_ANCHOR, sample_us, 1'b1, pick_epoch());
      done++;
      repeat ($urandom_range(3, 20)) begin
        sample_us = sample_us + pick_delta();
        pick      = $urandom_range(0, 99);
        if (pick < 40)
          send_item(FUNC_TICK, sample_us, 1'($urandom_range(0, 1)), $urandom);
        else if (pick < 65)
          send_item(FUNC_QUERY, sample_us, 1'($urandom_range(0, 1)), $urandom);
        else if (pick < 92)
          send_item(FUNC_RESYNC, sample_us, 1'b1, pick_rtc());
        else
          send_item(3'($urandom_range(0, 7)), sample_us, 1'($urandom_range(0, 1)),
                    $urandom);
        done++;
      end
    end
  endtask

  // Result side: check every output transfer and stall in bursts or long holds.
  initial begin
    int burst;
    burst = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) tracker.check_report(out_tuser, out_tdata);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (burst > 0) begin
        out_tready <= 1'b0;
        burst--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        burst = $urandom_range(0, 6);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("wall_clock_seconds_keeper_tb NOT OK");
    $finish;
  end

  initial begin
    tracker   = new();
    idle_on   = 1'b1;
    hold_left = 0;
    sample_us = '0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= FUNC_RESET;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_DRIFT_LIMIT;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items run on the reset values of both limits.
    run_directed();
    settle_and_configure(16'd0, 16'd0);
    run_random(190);
    settle_and_configure(16'hFFFF, 16'hFFFF);
    // Long receiver hold while items keep coming, so the input backs up.
    hold_left = 80;
    run_random(190);
    settle_and_configure(16'd1, 16'd3);
    run_random(190);
    settle_and_configure(16'($urandom), 16'($urandom_range(0, 40)));
    hold_left = 60;
    run_random(190);
    settle_and_configure(16'($urandom_range(0, 10)), 16'($urandom));
    run_random(190);
    // Closing phase at full rate on both sides.
    idle_on = 1'b0;
    settle_and_configure(16'd2, 16'd5);
    run_random(190);

    in_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("wall_clock_seconds_keeper_tb OK");
    end else begin
      $display("wall_clock_seconds_keeper_tb NOT OK");
    end
    $finish;
  end

endmodule
